// File: hw/rtl/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the JSON string unescaper queue and emitter modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jsu_pkg.sv
// Shared types, character codes and UTF-8 helpers of the JSON string unescaper.
package jsu_pkg;

    // Decoder modes
    typedef enum logic [2:0] {
        MODE_TEXT  = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_PAIR0 = 3'd3,
        MODE_PAIR1 = 3'd4
    } mode_t;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_LA     = 8'h61;

    // Surrogate and UTF-8 constants
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] UTF8_LIM1   = 21'h00080;
    localparam logic [20:0] UTF8_LIM2   = 21'h00800;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4  = 8'hF0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [7:0]  UTF8_MASK   = 8'h3F;

    localparam logic [1:0]  LAST_DIGIT  = 2'd3;

    // Descriptor queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input byte's worth of results, as segments in output order:
    // held surrogate, 'u', raw hex digits, code point, single byte, marker.
    typedef struct packed {
        logic [9:0]  hi_val;
        logic [1:0]  dig_k;
        logic [11:0] dig_buf;
        logic [2:0]  dig_case;
        logic [2:0]  cp_len;
        logic [20:0] cp_val;
        logic [7:0]  b_val;
        logic [3:0]  o_u;
        logic [3:0]  o_dig;
        logic [3:0]  o_cp;
        logic [3:0]  o_b;
        logic [3:0]  o_mk;
        logic [3:0]  total;
    } desc_t;

    // Rebuild a held high surrogate from its low ten bits
    function automatic logic [20:0] surr_cp(input logic [9:0] held);
        surr_cp = {5'b0, SURR_HI_MIN[15:10], held};
    endfunction

    // Number of UTF-8 bytes for a code point
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        if (cp < UTF8_LIM1) begin
            utf8_len = 3'd1;
        end else if (cp < UTF8_LIM2) begin
            utf8_len = 3'd2;
        end else if (cp < SUPP_BASE) begin
            utf8_len = 3'd3;
        end else begin
            utf8_len = 3'd4;
        end
    endfunction

    // Byte idx of the UTF-8 encoding of cp, which is len bytes long
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        c0 = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
        c1 = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
        c2 = UTF8_CONT | ({2'b00, cp[17:12]} & UTF8_MASK);
        case (len)
            3'd1: utf8_byte = {1'b0, cp[6:0]};
            3'd2: utf8_byte = (idx == 2'd0) ? (UTF8_LEAD2 | {3'b000, cp[10:6]}) : c0;
            3'd3: begin
                case (idx)
                    2'd0:    utf8_byte = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    utf8_byte = c1;
                    default: utf8_byte = c0;
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    utf8_byte = UTF8_LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    utf8_byte = c2;
                    2'd2:    utf8_byte = c1;
                    default: utf8_byte = c0;
                endcase
            end
        endcase
    endfunction

endpackage

// File: hw/rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: raw message bytes in, decoded UTF-8 results out.
// Path: a taken byte's descriptor is registered in the descriptor queue, and its
// results then go one at a time through the output register until each is taken.
// Throughput: one byte per cycle if bytes yield at most one result and m_ready is high;
// more results hold the output longer, a 4-entry descriptor queue absorbs the bursts.
// Reset: synchronous active-low aresetn clears decoder state, queue and output valid.
module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_string_end,
    output logic       m_last_of_run
);
    import jsu_pkg::*;

    logic  q_full;
    logic  q_push;
    desc_t q_wdata;
    logic  q_pop;
    logic  q_valid;
    desc_t q_head;

    jsu_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_message (s_end_of_message),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_desc           (q_wdata)
    );

    jsu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    jsu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_desc        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_string_end  (m_string_end),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// File: hw/rtl/jsu_queue.sv
// Short register queue of result descriptors between decoder front and emitter.
`include "json_string_unescape_utf8_macros.svh"

module jsu_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jsu_pkg::desc_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output jsu_pkg::desc_t head_data
);
    import jsu_pkg::*;

    desc_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed descriptor
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `JSU_ASSERT_IMP(a_push_not_full, aclk, aresetn, push, !full, "descriptor pushed into full queue")
    `JSU_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, pop, head_valid, "descriptor popped from empty queue")
    `JSU_ASSERT_NXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

// File: hw/rtl/jsu_front.sv
// Decoder front: takes message bytes, tracks escape state, builds result descriptors.
module jsu_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_in_byte,
    input  logic           s_end_of_message,
    input  logic           q_full,
    output logic           q_push,
    output jsu_pkg::desc_t q_desc
);
    import jsu_pkg::*;

    // Decoder state
    mode_t       mode_reg, mode_next, step_mode;
    logic [11:0] hexbuf_reg, hexbuf_next, step_hexbuf;
    logic [1:0]  cnt_reg, cnt_next, step_cnt;
    logic [2:0]  hcase_reg, hcase_next, step_hcase;
    logic [9:0]  held_reg, held_next, step_held;
    logic        hp_reg, hp_next, step_hp;
    logic        closed_reg, closed_next, step_closed;

    logic        accept;
    logic [7:0]  in_c;
    logic        is_hex;
    logic        is_upper;
    logic [3:0]  nib;
    logic [15:0] v;
    logic        v_low;
    logic        v_high;
    logic        pair;
    logic [20:0] pair_cp;
    logic        c_quote;
    logic        c_bslash;
    mode_t       text_mode;
    logic [7:0]  esc_byte;

    // Segment enables and offsets of the descriptor
    logic        hi_en, u_en, b_en, mk_en;
    logic [3:0]  l_hi, l_dig, l_cp;
    desc_t       d;

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_full;
    assign in_c    = s_in_byte;

    // Classify the incoming byte
    always_comb begin
        is_hex   = 1'b0;
        is_upper = 1'b0;
        nib      = in_c[3:0];
        if (in_c inside {[8'h30:8'h39]}) begin
            is_hex = 1'b1;
        end else if (in_c inside {[8'h61:8'h66]}) begin
            is_hex = 1'b1;
            nib    = in_c[3:0] + 4'd9;
        end else if (in_c inside {[8'h41:8'h46]}) begin
            is_hex   = 1'b1;
            is_upper = 1'b1;
            nib      = in_c[3:0] + 4'd9;
        end
        c_quote   = (in_c == CH_QUOTE);
        c_bslash  = (in_c == CH_BSLASH);
        text_mode = c_bslash ? MODE_ESC : MODE_TEXT;
        v         = {hexbuf_reg, nib};
        v_low     = v inside {[SURR_LO_MIN:SURR_LO_MAX]};
        v_high    = v inside {[SURR_HI_MIN:SURR_HI_MAX]};
        pair      = hp_reg && v_low;
        pair_cp   = SUPP_BASE + {1'b0, held_reg, v[9:0]};
        case (in_c)
            CH_N:    esc_byte = CH_LF;
            CH_R:    esc_byte = CH_CR;
            CH_T:    esc_byte = CH_TAB;
            CH_B:    esc_byte = CH_BS;
            CH_F:    esc_byte = CH_FF;
            default: esc_byte = in_c;
        endcase
    end

    // State after handling the byte, before any message-end flush
    always_comb begin
        step_mode   = mode_reg;
        step_hexbuf = hexbuf_reg;
        step_cnt    = cnt_reg;
        step_hcase  = hcase_reg;
        step_held   = held_reg;
        step_hp     = hp_reg;
        step_closed = closed_reg;
        if (!closed_reg) begin
            case (mode_reg)
                MODE_ESC: begin
                    step_mode = (in_c == CH_U) ? MODE_HEX : MODE_TEXT;
                    step_hexbuf = '0;
                    step_cnt    = '0;
                    step_hcase  = '0;
                end
                MODE_HEX: begin
                    if (!is_hex) begin
                        step_hp     = 1'b0;
                        step_hexbuf = '0;
                        step_cnt    = '0;
                        step_hcase  = '0;
                        step_mode   = text_mode;
                        step_closed = c_quote;
                    end else if (cnt_reg == LAST_DIGIT) begin
                        step_hexbuf = '0;
                        step_cnt    = '0;
                        step_hcase  = '0;
                        step_hp     = 1'b0;
                        step_mode   = MODE_TEXT;
                        if (!pair && v_high) begin
                            step_held = v[9:0];
                            step_hp   = 1'b1;
                            step_mode = MODE_PAIR0;
                        end
                    end else begin
                        step_hexbuf = {hexbuf_reg[7:0], nib};
                        step_cnt    = cnt_reg + 2'd1;
                        if (is_upper) begin
                            step_hcase[cnt_reg] = 1'b1;
                        end
                    end
                end
                MODE_PAIR0: begin
                    if (c_bslash) begin
                        step_mode = MODE_PAIR1;
                    end else begin
                        step_hp     = 1'b0;
                        step_mode   = text_mode;
                        step_closed = c_quote;
                    end
                end
                MODE_PAIR1: begin
                    if (in_c == CH_U) begin
                        step_mode   = MODE_HEX;
                        step_hexbuf = '0;
                        step_cnt    = '0;
                        step_hcase  = '0;
                    end else begin
                        step_hp   = 1'b0;
                        step_mode = MODE_TEXT;
                    end
                end
                default: begin
                    step_mode   = text_mode;
                    step_closed = c_quote;
                end
            endcase
        end
    end

    // Next state: message end returns everything to reset
    always_comb begin
        mode_next   = mode_reg;
        hexbuf_next = hexbuf_reg;
        cnt_next    = cnt_reg;
        hcase_next  = hcase_reg;
        held_next   = held_reg;
        hp_next     = hp_reg;
        closed_next = closed_reg;
        if (accept) begin
            if (s_end_of_message) begin
                mode_next   = MODE_TEXT;
                hexbuf_next = '0;
                cnt_next    = '0;
                hcase_next  = '0;
                held_next   = '0;
                hp_next     = 1'b0;
                closed_next = 1'b0;
            end else begin
                mode_next   = step_mode;
                hexbuf_next = step_hexbuf;
                cnt_next    = step_cnt;
                hcase_next  = step_hcase;
                held_next   = step_held;
                hp_next     = step_hp;
                closed_next = step_closed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_TEXT;
            hexbuf_reg <= '0;
            cnt_reg    <= '0;
            hcase_reg  <= '0;
            held_reg   <= '0;
            hp_reg     <= 1'b0;
            closed_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            hexbuf_reg <= hexbuf_next;
            cnt_reg    <= cnt_next;
            hcase_reg  <= hcase_next;
            held_reg   <= held_next;
            hp_reg     <= hp_next;
            closed_reg <= closed_next;
        end
    end

    // Build the descriptor of this byte's results
    always_comb begin
        d     = '0;
        hi_en = 1'b0;
        u_en  = 1'b0;
        b_en  = 1'b0;
        mk_en = 1'b0;
        if (accept && !closed_reg) begin
            case (mode_reg)
                MODE_ESC: begin
                    if (in_c != CH_U) begin
                        b_en    = 1'b1;
                        d.b_val = esc_byte;
                    end
                end
                MODE_HEX: begin
                    if (!is_hex) begin
                        hi_en      = hp_reg;
                        d.hi_val   = held_reg;
                        u_en       = 1'b1;
                        d.dig_k    = cnt_reg;
                        d.dig_buf  = hexbuf_reg;
                        d.dig_case = hcase_reg;
                        mk_en      = c_quote;
                        b_en       = !c_quote && !c_bslash;
                        d.b_val    = in_c;
                    end else if (cnt_reg == LAST_DIGIT) begin
                        if (pair) begin
                            d.cp_val = pair_cp;
                            d.cp_len = 3'd4;
                        end else begin
                            hi_en    = hp_reg;
                            d.hi_val = held_reg;
                            if (!v_high) begin
                                d.cp_val = {5'b0, v};
                                d.cp_len = utf8_len({5'b0, v});
                            end
                        end
                    end
                end
                MODE_PAIR0: begin
                    if (!c_bslash) begin
                        hi_en    = 1'b1;
                        d.hi_val = held_reg;
                        mk_en    = c_quote;
                        b_en     = !c_quote;
                        d.b_val  = in_c;
                    end
                end
                MODE_PAIR1: begin
                    if (in_c != CH_U) begin
                        hi_en    = 1'b1;
                        d.hi_val = held_reg;
                        b_en     = 1'b1;
                        d.b_val  = esc_byte;
                    end
                end
                default: begin
                    mk_en   = c_quote;
                    b_en    = !c_quote && !c_bslash;
                    d.b_val = in_c;
                end
            endcase
        end
        // Flush what is still pending at message end, then mark the string end
        if (accept && s_end_of_message && !step_closed) begin
            case (step_mode)
                MODE_ESC: begin
                    b_en    = 1'b1;
                    d.b_val = CH_BSLASH;
                end
                MODE_HEX: begin
                    hi_en      = step_hp;
                    d.hi_val   = step_held;
                    u_en       = 1'b1;
                    d.dig_k    = step_cnt;
                    d.dig_buf  = step_hexbuf;
                    d.dig_case = step_hcase;
                end
                MODE_PAIR0: begin
                    if (step_hp) begin
                        d.cp_val = surr_cp(step_held);
                        d.cp_len = 3'd3;
                    end
                end
                MODE_PAIR1: begin
                    hi_en    = step_hp;
                    d.hi_val = step_held;
                    b_en     = 1'b1;
                    d.b_val  = CH_BSLASH;
                end
                default: begin
                    b_en = b_en;
                end
            endcase
            mk_en = 1'b1;
        end
        // Lay out segment offsets
        l_hi    = hi_en ? 4'd3 : 4'd0;
        l_dig   = {2'b00, d.dig_k};
        l_cp    = {1'b0, d.cp_len};
        d.o_u   = l_hi;
        d.o_dig = d.o_u + {3'b000, u_en};
        d.o_cp  = d.o_dig + l_dig;
        d.o_b   = d.o_cp + l_cp;
        d.o_mk  = d.o_b + {3'b000, b_en};
        d.total = d.o_mk + {3'b000, mk_en};
    end

    assign q_desc = d;
    assign q_push = accept && (d.total != 4'd0);

endmodule

// File: hw/rtl/jsu_back.sv
// Result emitter: walks each descriptor one output byte per cycle unless m_ready stalls.
`include "json_string_unescape_utf8_macros.svh"

module jsu_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  jsu_pkg::desc_t q_desc,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_byte_valid,
    output logic           m_string_end,
    output logic           m_last_of_run
);
    import jsu_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       string_end_reg;
    logic       last_reg;

    logic       load;
    logic [7:0] res_byte;
    logic       res_valid;
    logic       res_end;
    logic       res_last;
    logic [3:0] dig_off;
    logic [3:0] cp_off;
    logic [1:0] dig_sel;
    logic [3:0] dig_nib;
    logic       dig_up;

    // Hex digit back to its original character
    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic up);
        if (n < 4'd10) begin
            hex_char = CH_0 + {4'b0000, n};
        end else begin
            hex_char = (up ? CH_UA : CH_LA) + {4'b0000, n} - 8'd10;
        end
    endfunction

    // Pick the result at the current position of the head descriptor
    always_comb begin
        dig_off   = pos_reg - q_desc.o_dig;
        cp_off    = pos_reg - q_desc.o_cp;
        dig_sel   = q_desc.dig_k - 2'd1 - dig_off[1:0];
        case (dig_sel)
            2'd0:    dig_nib = q_desc.dig_buf[3:0];
            2'd1:    dig_nib = q_desc.dig_buf[7:4];
            default: dig_nib = q_desc.dig_buf[11:8];
        endcase
        dig_up    = q_desc.dig_case[dig_off[1:0]];
        res_byte  = '0;
        res_valid = 1'b1;
        res_end   = 1'b0;
        if (pos_reg < q_desc.o_u) begin
            res_byte = utf8_byte(surr_cp(q_desc.hi_val), 3'd3, pos_reg[1:0]);
        end else if (pos_reg < q_desc.o_dig) begin
            res_byte = CH_U;
        end else if (pos_reg < q_desc.o_cp) begin
            res_byte = hex_char(dig_nib, dig_up);
        end else if (pos_reg < q_desc.o_b) begin
            res_byte = utf8_byte(q_desc.cp_val, q_desc.cp_len, cp_off[1:0]);
        end else if (pos_reg < q_desc.o_mk) begin
            res_byte = q_desc.b_val;
        end else begin
            res_valid = 1'b0;
            res_end   = 1'b1;
        end
        res_last = (pos_reg == q_desc.total - 4'd1);
    end

    // Advance through the descriptor when the output register can take a transaction
    assign load  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = load && res_last;

    always_comb begin
        pos_next = pos_reg;
        if (load) begin
            pos_next = res_last ? 4'd0 : pos_reg + 4'd1;
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_valid;
            string_end_reg <= res_end;
            last_reg       <= res_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_byte_valid  = byte_valid_reg;
    assign m_string_end  = string_end_reg;
    assign m_last_of_run = last_reg;

    `JSU_ASSERT_IMP(a_marker_last, aclk, aresetn, m_valid && m_string_end, m_last_of_run && !m_byte_valid && (m_out_byte == 8'h00), "string end marker is not a bare last result")
    `JSU_ASSERT_IMP(a_pos_in_run, aclk, aresetn, q_valid, pos_reg < q_desc.total, "emit position beyond descriptor length")

endmodule
